// File: rtl/dscb_pkg.sv
// ----------------------------------------------------------------------------
// Double-sided Crystal Ball evaluator: shared package
// Region codes, register indexes, fixed-point constants and the elaboration
// time function that builds the 2^(-2^-j) root table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dscb_pkg;

	localparam int FRAC_BITS = 24;

	// log2(e) in Q.30
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	// Exponent integer part from which the result is zero.
	localparam logic [14:0] K_ZERO = 15'd33;

	localparam logic [1:0] REGION_CORE = 2'd0;
	localparam logic [1:0] REGION_LOW  = 2'd1;
	localparam logic [1:0] REGION_HIGH = 2'd2;

	localparam logic [2:0] REG_ALPHA_LOW  = 3'd0;
	localparam logic [2:0] REG_ALPHA_HIGH = 3'd1;
	localparam logic [2:0] REG_POWER_LOW  = 3'd2;
	localparam logic [2:0] REG_POWER_HIGH = 3'd3;
	localparam logic [2:0] REG_PEAK_MEAN  = 3'd4;
	localparam logic [2:0] REG_CORE_WIDTH = 3'd5;
	localparam logic [2:0] REG_NORM_SCALE = 3'd6;

	// Truncated integer square root, used only on constants.
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rest;
		logic [63:0] res;
		logic [63:0] bv;
		rest = v;
		res  = '0;
		bv   = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rest >= res + bv) begin
				rest = rest - (res + bv);
				res  = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	// Entry j is 2^(-2^-(j+1)) in Q.30, each the root of the one before.
	function automatic logic [29:0] root_entry(input int j);
		logic [63:0] r;
		r = isqrt64(64'd1 << 59);
		for (int i = 1; i <= j; i++) begin
			r = isqrt64(r << 30);
		end
		return r[29:0];
	endfunction

endpackage

// File: rtl/dscb_if.sv
// ----------------------------------------------------------------------------
// Double-sided Crystal Ball evaluator: stream interfaces
// Sample and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dscb_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink (input valid, input x_value, output ready);
endinterface

interface dscb_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] y_value;
	logic [1:0]  region;

	modport source (output valid, output y_value, output region, input ready);
	modport sink (input valid, input y_value, input region, output ready);
endinterface

// File: rtl/double_sided_crystal_ball_eval_top.sv
// ----------------------------------------------------------------------------
// Double-sided Crystal Ball evaluator, top level
// The block takes one Q16.16 sample position per beat on the sample channel
// and returns the double-sided Crystal Ball value (Q16.16, saturated) and the
// region code on the result channel. It is a fully pipelined chain of cells:
// a 57-cell restoring divider forms t = (x - mean) / sigma, a 59-cell divider
// scales the tail distance by alpha / n, 24 squaring cells extract log2 for
// the power law and 24 root-table cells form 2^(-E). A new beat is accepted
// every clock while the output buffer has room. A two-entry output buffer
// decouples the channels, so a waiting result does not block the input
// until the buffer is full. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata and must only change while no beat is in
// flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_sided_crystal_ball_eval_top
	import dscb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_wdata,
	dscb_sample_if.sink   sample,
	dscb_result_if.source result
);

	localparam int Q1W = 57;	// |t| quotient width, Q.24
	localparam int Q2W = 59;	// scaled tail distance width

	typedef struct packed {
		logic [1:0]  region;
		logic [3:0]  sh;
		logic [31:0] e2c;
		logic [31:0] e2a;
	} div2_side_t;

	typedef struct packed {
		logic [1:0]  region;
		logic [15:0] n;
		logic [5:0]  ips;
		logic [31:0] e2c;
		logic [31:0] e2a;
	} log_side_t;

	typedef struct packed {
		logic [1:0]  region;
		logic [14:0] k;
	} exp_side_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0] alpha_low_q;
	logic [15:0] alpha_high_q;
	logic [15:0] power_low_q;
	logic [15:0] power_high_q;
	logic [31:0] peak_mean_q;
	logic [30:0] core_width_q;
	logic [31:0] norm_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_low_q  <= 16'd4096;
			alpha_high_q <= 16'd4096;
			power_low_q  <= 16'd512;
			power_high_q <= 16'd512;
			peak_mean_q  <= 32'd26214400;
			core_width_q <= 31'd655360;
			norm_scale_q <= 32'd196608000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA_LOW:  alpha_low_q  <= cfg_wdata[15:0];
				REG_ALPHA_HIGH: alpha_high_q <= cfg_wdata[15:0];
				REG_POWER_LOW:  power_low_q  <= cfg_wdata[15:0];
				REG_POWER_HIGH: power_high_q <= cfg_wdata[15:0];
				REG_PEAK_MEAN:  peak_mean_q  <= cfg_wdata;
				REG_CORE_WIDTH: core_width_q <= cfg_wdata[30:0];
				REG_NORM_SCALE: norm_scale_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// A zero register acts as the smallest positive value.
	logic [15:0] al_eff;
	logic [15:0] ah_eff;
	logic [15:0] nl_eff;
	logic [15:0] nh_eff;
	logic [30:0] sig_eff;

	assign al_eff  = (alpha_low_q == '0) ? 16'd1 : alpha_low_q;
	assign ah_eff  = (alpha_high_q == '0) ? 16'd1 : alpha_high_q;
	assign nl_eff  = (power_low_q == '0) ? 16'd1 : power_low_q;
	assign nh_eff  = (power_high_q == '0) ? 16'd1 : power_high_q;
	assign sig_eff = (core_width_q == '0) ? 31'd1 : core_width_q;

	// ------------------------------------------------------------------
	// Flow control: the whole chain advances together while the output
	// buffer has room. Its count is registered, so ready on the sample
	// side never depends combinationally on the result side.
	// ------------------------------------------------------------------
	logic [1:0] cnt_q;
	logic       en;

	assign en           = (cnt_q != 2'd2);
	assign sample.ready = en;

	// ------------------------------------------------------------------
	// Stage 1: distance from the mean and the tail thresholds alpha*sigma.
	// ------------------------------------------------------------------
	logic signed [32:0] dlt;
	logic [32:0]        dlt_u;
	logic [32:0]        mag;
	logic [46:0]        lim_lo;
	logic [46:0]        lim_hi;

	assign dlt    = $signed({sample.x_value[31], sample.x_value})
		- $signed({peak_mean_q[31], peak_mean_q});
	assign dlt_u  = dlt;
	assign mag    = dlt_u[32] ? (~dlt_u + 33'd1) : dlt_u;
	assign lim_lo = al_eff * sig_eff;
	assign lim_hi = ah_eff * sig_eff;

	logic        v_s1;
	logic [32:0] mag_s1;
	logic        neg_s1;
	logic        pos_s1;
	logic [46:0] lim_lo_s1;
	logic [46:0] lim_hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1    <= mag;
			neg_s1    <= dlt_u[32];
			pos_s1    <= !dlt_u[32] && (dlt_u != '0);
			lim_lo_s1 <= lim_lo;
			lim_hi_s1 <= lim_hi;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: exact region decision, |d|*4096 against alpha*sigma.
	// ------------------------------------------------------------------
	logic [46:0] mag_sc;
	logic [1:0]  region_n2;

	assign mag_sc = {2'b00, mag_s1, 12'd0};

	always_comb begin
		if (neg_s1 && (mag_sc > lim_lo_s1)) begin
			region_n2 = REGION_LOW;
		end else if (pos_s1 && (mag_sc > lim_hi_s1)) begin
			region_n2 = REGION_HIGH;
		end else begin
			region_n2 = REGION_CORE;
		end
	end

	logic        v_s2;
	logic [32:0] mag_s2;
	logic [1:0]  region_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2    <= mag_s1;
			region_s2 <= region_n2;
		end
	end

	// ------------------------------------------------------------------
	// Divider chain 1: |t| = floor(|d| * 2^24 / sigma) in Q.24.
	// ------------------------------------------------------------------
	logic           v1    [0:Q1W];
	logic [30:0]    rem1  [0:Q1W];
	logic [30:0]    dvs1  [0:Q1W];
	logic [Q1W-1:0] word1 [0:Q1W];
	logic [1:0]     side1 [0:Q1W];

	assign v1[0]    = v_s2;
	assign rem1[0]  = '0;
	assign dvs1[0]  = sig_eff;
	assign word1[0] = {mag_s2, 24'd0};
	assign side1[0] = region_s2;

	for (genvar g = 0; g < Q1W; g++) begin : g_div1
		dscb_div_cell #(
			.NW(Q1W),
			.DW(31),
			.SW(2)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (v1[g]),
			.rem_i   (rem1[g]),
			.dvs_i   (dvs1[g]),
			.word_i  (word1[g]),
			.side_i  (side1[g]),
			.valid_o (v1[g+1]),
			.rem_o   (rem1[g+1]),
			.dvs_o   (dvs1[g+1]),
			.word_o  (word1[g+1]),
			.side_o  (side1[g+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage 3: core square, tail distance u = |t| - alpha, alpha^2/2.
	// In the core |t| stays at or below alpha, so 28 bits of it suffice.
	// ------------------------------------------------------------------
	logic [Q1W-1:0] tq;
	logic [1:0]     region_d1;
	logic [15:0]    a3;
	logic [Q1W-1:0] aq3;
	logic [55:0]    tsq;
	logic [31:0]    asq;

	assign tq        = word1[Q1W];
	assign region_d1 = side1[Q1W];
	assign a3        = (region_d1 == REGION_LOW) ? al_eff : ah_eff;
	assign aq3       = {29'd0, a3, 12'd0};
	assign tsq       = tq[27:0] * tq[27:0];
	assign asq       = a3 * a3;

	logic           v_s3;
	logic [1:0]     region_s3;
	logic [Q1W-1:0] u_s3;
	logic [30:0]    hsq_s3;
	logic [30:0]    aah_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v1[Q1W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_s3 <= region_d1;
			u_s3      <= (tq > aq3) ? (tq - aq3) : '0;
			hsq_s3    <= tsq[55:25];
			aah_s3    <= asq[31:1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: both exponents times log2(e); u brought below 2^47.
	// ------------------------------------------------------------------
	logic [61:0]    ec;
	logic [61:0]    ea;
	logic [3:0]     sh4;
	logic [Q1W-1:0] us_full;

	assign ec = hsq_s3 * LOG2E_Q30;
	assign ea = aah_s3 * LOG2E_Q30;

	always_comb begin
		sh4 = '0;
		for (int i = 0; i < 10; i++) begin
			if (u_s3[47+i]) begin
				sh4 = 4'(i + 1);
			end
		end
	end

	assign us_full = u_s3 >> sh4;

	logic        v_s4;
	logic [1:0]  region_s4;
	logic [46:0] us_s4;
	logic [3:0]  sh_s4;
	logic [31:0] e2c_s4;
	logic [31:0] e2a_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_s4 <= region_s3;
			us_s4     <= us_full[46:0];
			sh_s4     <= sh4;
			e2c_s4    <= ec[61:30];
			e2a_s4    <= ea[61:30];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: u * alpha / 16 and the exponent n of the side.
	// ------------------------------------------------------------------
	logic [15:0] a5;
	logic [15:0] n5;
	logic [62:0] ua;

	assign a5 = (region_s4 == REGION_LOW) ? al_eff : ah_eff;
	assign n5 = (region_s4 == REGION_LOW) ? nl_eff : nh_eff;
	assign ua = us_s4 * a5;

	logic           v_s5;
	logic [Q2W-1:0] p_s5;
	logic [15:0]    n_s5;
	div2_side_t     side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s5           <= ua[62:4];
			n_s5           <= n5;
			side_s5.region <= region_s4;
			side_s5.sh     <= sh_s4;
			side_s5.e2c    <= e2c_s4;
			side_s5.e2a    <= e2a_s4;
		end
	end

	// ------------------------------------------------------------------
	// Divider chain 2: r = floor(u * alpha / (16 n)).
	// ------------------------------------------------------------------
	logic           v2    [0:Q2W];
	logic [15:0]    rem2  [0:Q2W];
	logic [15:0]    dvs2  [0:Q2W];
	logic [Q2W-1:0] word2 [0:Q2W];
	div2_side_t     side2 [0:Q2W];

	assign v2[0]    = v_s5;
	assign rem2[0]  = '0;
	assign dvs2[0]  = n_s5;
	assign word2[0] = p_s5;
	assign side2[0] = side_s5;

	for (genvar g = 0; g < Q2W; g++) begin : g_div2
		dscb_div_cell #(
			.NW(Q2W),
			.DW(16),
			.SW($bits(div2_side_t))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (v2[g]),
			.rem_i   (rem2[g]),
			.dvs_i   (dvs2[g]),
			.word_i  (word2[g]),
			.side_i  (side2[g]),
			.valid_o (v2[g+1]),
			.rem_o   (rem2[g+1]),
			.dvs_o   (dvs2[g+1]),
			.word_o  (word2[g+1]),
			.side_o  (side2[g+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage 6: power-law base B = r + (1.0 >> s).
	// ------------------------------------------------------------------
	div2_side_t  sd6;
	logic [24:0] pw6;

	assign sd6 = side2[Q2W];
	assign pw6 = 25'h100_0000 >> sd6.sh;

	logic        v_s6;
	logic [59:0] b_s6;
	logic [15:0] n_s6;
	div2_side_t  sd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v2[Q2W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s6  <= {1'b0, word2[Q2W]} + {35'd0, pw6};
			n_s6  <= dvs2[Q2W];
			sd_s6 <= sd6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: leading one of B gives the integer part of log2.
	// ------------------------------------------------------------------
	logic [5:0] lead7;

	always_comb begin
		lead7 = '0;
		for (int i = 0; i < 60; i++) begin
			if (b_s6[i]) begin
				lead7 = 6'(i);
			end
		end
	end

	logic        v_s7;
	logic [59:0] b_s7;
	logic [5:0]  lead_s7;
	logic [15:0] n_s7;
	div2_side_t  sd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s7    <= b_s6;
			lead_s7 <= lead7;
			n_s7    <= n_s6;
			sd_s7   <= sd_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: normalize B to a Q.30 mantissa in [1, 2).
	// ------------------------------------------------------------------
	logic [59:0] nb8;
	logic [5:0]  ip8;

	assign nb8 = (lead_s7 > 6'd30) ? (b_s7 >> (lead_s7 - 6'd30))
		: (b_s7 << (6'd30 - lead_s7));
	assign ip8 = (lead_s7 >= 6'd24) ? (lead_s7 - 6'd24) : 6'd0;

	logic        v_s8;
	logic [30:0] mant_s8;
	log_side_t   ls_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_s8      <= nb8[30:0];
			ls_s8.region <= sd_s7.region;
			ls_s8.n      <= n_s7;
			ls_s8.ips    <= ip8 + {2'b00, sd_s7.sh};
			ls_s8.e2c    <= sd_s7.e2c;
			ls_s8.e2a    <= sd_s7.e2a;
		end
	end

	// ------------------------------------------------------------------
	// Log chain: 24 fraction bits of log2 by repeated squaring.
	// ------------------------------------------------------------------
	logic                 vl    [0:FRAC_BITS];
	logic [30:0]          mantl [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] fracl [0:FRAC_BITS];
	log_side_t            sidel [0:FRAC_BITS];

	assign vl[0]    = v_s8;
	assign mantl[0] = mant_s8;
	assign fracl[0] = '0;
	assign sidel[0] = ls_s8;

	for (genvar g = 0; g < FRAC_BITS; g++) begin : g_log
		dscb_log_cell #(
			.SW($bits(log_side_t))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (vl[g]),
			.mant_i  (mantl[g]),
			.frac_i  (fracl[g]),
			.side_i  (sidel[g]),
			.valid_o (vl[g+1]),
			.mant_o  (mantl[g+1]),
			.frac_o  (fracl[g+1]),
			.side_o  (sidel[g+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage 9: n * log2(B) in Q.24.
	// ------------------------------------------------------------------
	log_side_t   sd9;
	logic [29:0] lg9;
	logic [45:0] nlg9;

	assign sd9  = sidel[FRAC_BITS];
	assign lg9  = {sd9.ips, fracl[FRAC_BITS]};
	assign nlg9 = sd9.n * lg9;

	logic        v_s9;
	logic [37:0] nl_s9;
	logic [1:0]  region_s9;
	logic [31:0] e2c_s9;
	logic [31:0] e2a_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= vl[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s9     <= nlg9[45:8];
			region_s9 <= sd9.region;
			e2c_s9    <= sd9.e2c;
			e2a_s9    <= sd9.e2a;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: total base-2 exponent E2 of the region.
	// ------------------------------------------------------------------
	logic        v_s10;
	logic [38:0] e2_s10;
	logic [1:0]  region_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e2_s10     <= (region_s9 == REGION_CORE) ? {7'd0, e2c_s9}
				: ({7'd0, e2a_s9} + {1'b0, nl_s9});
			region_s10 <= region_s9;
		end
	end

	// ------------------------------------------------------------------
	// Exp chain: 2^(-fraction) as a product of root-table entries.
	// ------------------------------------------------------------------
	logic                 ve    [0:FRAC_BITS];
	logic [30:0]          mante [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] frace [0:FRAC_BITS];
	exp_side_t            sidee [0:FRAC_BITS];

	assign ve[0]           = v_s10;
	assign mante[0]        = 31'h4000_0000;
	assign frace[0]        = e2_s10[FRAC_BITS-1:0];
	assign sidee[0].region = region_s10;
	assign sidee[0].k      = e2_s10[38:FRAC_BITS];

	for (genvar g = 0; g < FRAC_BITS; g++) begin : g_exp
		dscb_exp_cell #(
			.J  (g),
			.SW ($bits(exp_side_t))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (ve[g]),
			.mant_i  (mante[g]),
			.frac_i  (frace[g]),
			.side_i  (sidee[g]),
			.valid_o (ve[g+1]),
			.mant_o  (mante[g+1]),
			.frac_o  (frace[g+1]),
			.side_o  (sidee[g+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage 11: norm times the mantissa; an exponent of 33 or more
	// forces the result to zero.
	// ------------------------------------------------------------------
	exp_side_t   sd11;
	logic [62:0] nm11;

	assign sd11 = sidee[FRAC_BITS];
	assign nm11 = norm_scale_q * mante[FRAC_BITS];

	logic        v_s11;
	logic [62:0] prod_s11;
	logic [5:0]  k_s11;
	logic        zero_s11;
	logic [1:0]  region_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= ve[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s11   <= nm11;
			k_s11      <= sd11.k[5:0];
			zero_s11   <= (sd11.k >= K_ZERO);
			region_s11 <= sd11.region;
		end
	end

	// ------------------------------------------------------------------
	// Stage 12: add half an output LSB at the final scale.
	// ------------------------------------------------------------------
	logic [6:0] rs12;

	assign rs12 = {1'b0, k_s11} + 7'd29;

	logic        v_s12;
	logic [63:0] sum_s12;
	logic [5:0]  k_s12;
	logic        zero_s12;
	logic [1:0]  region_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s12    <= {1'b0, prod_s11} + (64'd1 << rs12);
			k_s12      <= k_s11;
			zero_s12   <= zero_s11;
			region_s12 <= region_s11;
		end
	end

	// ------------------------------------------------------------------
	// Final shift and saturation, written into the output buffer.
	// ------------------------------------------------------------------
	logic [6:0]  rs13;
	logic [63:0] shr13;
	logic [31:0] y13;

	assign rs13  = {1'b0, k_s12} + 7'd30;
	assign shr13 = sum_s12 >> rs13;
	assign y13   = zero_s12 ? 32'd0
		: ((shr13[63:32] != '0) ? 32'hFFFF_FFFF : shr13[31:0]);

	logic [31:0] fy_q [0:1];
	logic [1:0]  fr_q [0:1];
	logic        wr_q;
	logic        rd_q;
	logic        push;
	logic        pop;

	assign push = v_s12 && en;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fy_q[wr_q] <= y13;
			fr_q[wr_q] <= region_s12;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign result.valid   = (cnt_q != 2'd0);
	assign result.y_value = fy_q[rd_q];
	assign result.region  = fr_q[rd_q];

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_region_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.region == REGION_CORE || result.region == REGION_LOW
		|| result.region == REGION_HIGH))
		else $error("invalid region code on result");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !(result.valid && result.ready)) |=> !sample.ready)
		else $error("sample accepted while output buffer full");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && v_s12 && en) |=> result.valid)
		else $error("pushed result not presented");
`endif

endmodule

// File: rtl/dscb_div_cell.sv
// ----------------------------------------------------------------------------
// Restoring divider cell
// One quotient bit per cell; the dividend word shifts left and collects the
// quotient bits, so after NW cells it holds the quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dscb_div_cell #(
	parameter int NW = 57,
	parameter int DW = 31,
	parameter int SW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_i,
	input  logic [DW-1:0] rem_i,
	input  logic [DW-1:0] dvs_i,
	input  logic [NW-1:0] word_i,
	input  logic [SW-1:0] side_i,
	output logic          valid_o,
	output logic [DW-1:0] rem_o,
	output logic [DW-1:0] dvs_o,
	output logic [NW-1:0] word_o,
	output logic [SW-1:0] side_o
);

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic          valid_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [NW-1:0] word_q;
	logic [SW-1:0] side_q;

	assign trial = {rem_i, word_i[NW-1]};
	assign diff  = trial - {1'b0, dvs_i};
	assign ge    = (trial >= {1'b0, dvs_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			dvs_q  <= dvs_i;
			word_q <= {word_i[NW-2:0], ge};
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign rem_o   = rem_q;
	assign dvs_o   = dvs_q;
	assign word_o  = word_q;
	assign side_o  = side_q;

endmodule

// File: rtl/dscb_log_cell.sv
// ----------------------------------------------------------------------------
// Logarithm cell
// Squares a Q.30 mantissa in [1, 2) and yields one fraction bit of log2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dscb_log_cell
	import dscb_pkg::*;
#(
	parameter int SW = 88
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_i,
	input  logic [30:0]          mant_i,
	input  logic [FRAC_BITS-1:0] frac_i,
	input  logic [SW-1:0]        side_i,
	output logic                 valid_o,
	output logic [30:0]          mant_o,
	output logic [FRAC_BITS-1:0] frac_o,
	output logic [SW-1:0]        side_o
);

	logic [61:0]          sq;
	logic [31:0]          sq_hi;
	logic                 ovf;
	logic                 valid_q;
	logic [30:0]          mant_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [SW-1:0]        side_q;

	assign sq    = mant_i * mant_i;
	assign sq_hi = sq[61:30];
	assign ovf   = sq_hi[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_q <= ovf ? sq_hi[31:1] : sq_hi[30:0];
			frac_q <= {frac_i[FRAC_BITS-2:0], ovf};
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign mant_o  = mant_q;
	assign frac_o  = frac_q;
	assign side_o  = side_q;

endmodule

// File: rtl/dscb_exp_cell.sv
// ----------------------------------------------------------------------------
// Power-of-two cell
// Multiplies the Q.30 mantissa by 2^(-2^-(J+1)) when its exponent fraction
// bit is set, rounding half up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dscb_exp_cell
	import dscb_pkg::*;
#(
	parameter int J  = 0,
	parameter int SW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_i,
	input  logic [30:0]          mant_i,
	input  logic [FRAC_BITS-1:0] frac_i,
	input  logic [SW-1:0]        side_i,
	output logic                 valid_o,
	output logic [30:0]          mant_o,
	output logic [FRAC_BITS-1:0] frac_o,
	output logic [SW-1:0]        side_o
);

	localparam logic [29:0] ROOT = root_entry(J);

	logic [60:0]          prod;
	logic [60:0]          rnd;
	logic                 sel;
	logic                 valid_q;
	logic [30:0]          mant_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [SW-1:0]        side_q;

	assign prod = mant_i * ROOT;
	assign rnd  = prod + (61'd1 << 29);
	assign sel  = frac_i[FRAC_BITS-1-J];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mant_q <= sel ? rnd[60:30] : mant_i;
			frac_q <= frac_i;
			side_q <= side_i;
		end
	end

	assign valid_o = valid_q;
	assign mant_o  = mant_q;
	assign frac_o  = frac_q;
	assign side_o  = side_q;

endmodule

// File: test/dscb_checker.sv
// ----------------------------------------------------------------------------
// Crystal Ball evaluator checker
// Watches the register port and both channels. It predicts the value and
// region of each accepted sample and compares them with the result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dscb_checker
	import dscb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	dscb_sample_if      sample,
	dscb_result_if      result,
	output int          fails,
	output int          pending
);

	typedef struct packed {
		logic [31:0] y_value;
		logic [1:0]  region;
	} crystal_result_t;

	crystal_result_t expected_results[$];
	logic [63:0]     pow2_roots[FRAC_BITS];

	logic [15:0]        alpha_lo, alpha_hi, pow_lo, pow_hi;
	logic signed [31:0] mean_r;
	logic [30:0]        width_r;
	logic [31:0]        norm_r;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bv;
		res = 0;
		bv  = 64'd1 << 62;
		while (bv > v) bv = bv >> 2;
		while (bv != 0) begin
			if (v >= res + bv) begin
				v   = v - (res + bv);
				res = (res >> 1) + bv;
			end else begin
				res = res >> 1;
			end
			bv = bv >> 2;
		end
		return res;
	endfunction

	initial begin
		pow2_roots[0] = int_sqrt(64'd1 << 59);
		for (int j = 1; j < FRAC_BITS; j++)
			pow2_roots[j] = int_sqrt(pow2_roots[j - 1] << 30);
	end

	// log2(b / 2^24) + s in Q.24, fraction bits by repeated squaring.
	function automatic logic [63:0] log2_fixed(input logic [63:0] b, input int s);
		int          p;
		logic [63:0] m;
		logic [63:0] frac;
		logic [63:0] ip;
		p    = 0;
		frac = 0;
		while (p < 63 && (b >> (p + 1)) != 0) p++;
		m = (p > 30) ? (b >> (p - 30)) : (b << (30 - p));
		for (int i = 0; i < FRAC_BITS; i++) begin
			m    = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m    = m >> 1;
				frac = frac | 1;
			end
		end
		ip = (p >= 24) ? 64'(p - 24) : 0;
		return ((ip + 64'(s)) << FRAC_BITS) | frac;
	endfunction

	function automatic crystal_result_t crystal_ball_value(input logic signed [31:0] x);
		crystal_result_t res;
		longint          d;
		logic [63:0]     ad, sig, al, ah, tq, e2, a, n, u, r, b, lg, k, m, yy;
		int              s;
		d   = longint'(x) - longint'(mean_r);
		ad  = (d < 0) ? 64'(-d) : 64'(d);
		sig = (width_r != 0) ? 64'(width_r) : 1;
		al  = (alpha_lo != 0) ? 64'(alpha_lo) : 1;
		ah  = (alpha_hi != 0) ? 64'(alpha_hi) : 1;
		tq  = (ad << FRAC_BITS) / sig;
		if (d < 0 && ad * 4096 > al * sig) res.region = REGION_LOW;
		else if (d > 0 && ad * 4096 > ah * sig) res.region = REGION_HIGH;
		else res.region = REGION_CORE;

		if (res.region == REGION_CORE) begin
			e2 = (((tq * tq) >> 25) * 64'(LOG2E_Q30)) >> 30;
		end else begin
			a = (res.region == REGION_LOW) ? al : ah;
			n = (res.region == REGION_LOW) ? 64'(pow_lo) : 64'(pow_hi);
			if (n == 0) n = 1;
			u = (tq > (a << 12)) ? tq - (a << 12) : 0;
			s = 0;
			while ((u >> 47) != 0) begin
				u = u >> 1;
				s++;
			end
			r  = (u * a) / (n << 4);
			b  = r + ((64'd1 << FRAC_BITS) >> s);
			lg = log2_fixed(b, s);
			e2 = ((((a * a) >> 1) * 64'(LOG2E_Q30)) >> 30) + ((n * lg) >> 8);
		end

		k = e2 >> FRAC_BITS;
		if (k >= 33) begin
			res.y_value = 0;
		end else begin
			m = 64'd1 << 30;
			for (int j = 0; j < FRAC_BITS; j++)
				if (e2[FRAC_BITS - 1 - j]) m = (m * pow2_roots[j] + (64'd1 << 29)) >> 30;
			yy = (64'(norm_r) * m + (64'd1 << (29 + k))) >> (30 + k);
			res.y_value = (yy > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : yy[31:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		fails++;
	endtask

	initial fails = 0;
	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		crystal_result_t got, want;
		if (!arst_n) begin
			alpha_lo = 16'd4096;
			alpha_hi = 16'd4096;
			pow_lo   = 16'd512;
			pow_hi   = 16'd512;
			mean_r   = 32'sd26214400;
			width_r  = 31'd655360;
			norm_r   = 32'd196608000;
		end else begin
			if (result.valid && result.ready) begin
				got.y_value = result.y_value;
				got.region  = result.region;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result y=%h region=%0d",
						got.y_value, got.region));
				end else begin
					want = expected_results.pop_front();
					if (got.y_value !== want.y_value)
						report_mismatch($sformatf("y_value %h, expected %h",
							got.y_value, want.y_value));
					if (got.region !== want.region)
						report_mismatch($sformatf("region %0d, expected %0d",
							got.region, want.region));
				end
			end
			if (sample.valid && sample.ready)
				expected_results.push_back(crystal_ball_value(sample.x_value));
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHA_LOW:  alpha_lo = cfg_wdata[15:0];
					REG_ALPHA_HIGH: alpha_hi = cfg_wdata[15:0];
					REG_POWER_LOW:  pow_lo   = cfg_wdata[15:0];
					REG_POWER_HIGH: pow_hi   = cfg_wdata[15:0];
					REG_PEAK_MEAN:  mean_r   = cfg_wdata;
					REG_CORE_WIDTH: width_r  = cfg_wdata[30:0];
					REG_NORM_SCALE: norm_r   = cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Crystal Ball evaluator testbench
// Drives samples through the evaluator under a series of register settings
// and idling patterns; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
	import dscb_pkg::*;
;

	localparam int LATENCY     = 177;
	localparam int DRAIN_WAIT  = LATENCY + 40;
	localparam int STALL_LIMIT = 20000;

	// Idling patterns, one per phase.
	localparam int MODE_NONE   = 0;
	localparam int MODE_SENDER = 1;
	localparam int MODE_RECV   = 2;
	localparam int MODE_BOTH   = 3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	int          fails;
	int          pending;
	int          idle_mode;
	int          hold_left;

	// Shadow of the center and width, used to aim samples at the region edges.
	logic signed [31:0] cur_mean;
	logic [30:0]        cur_width;

	dscb_sample_if sample();
	dscb_result_if result();

	double_sided_crystal_ball_eval_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample   (sample),
		.result   (result)
	);

	dscb_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample   (sample),
		.result   (result),
		.fails    (fails),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// The receiver changes ready only at the falling edge. A requested hold-off
	// takes priority over the random stalls of the current pattern.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (idle_mode == MODE_RECV) begin
			result.ready <= ($urandom_range(99) >= 85);
		end else if (idle_mode == MODE_BOTH) begin
			result.ready <= ($urandom_range(99) >= 17);
		end else begin
			result.ready <= 1'b1;
		end
	end

	// Watchdog: a long run of cycles with no beat on either channel is a hang.
	always @(posedge clk) begin
		int quiet;
		if ((sample.valid && sample.ready) || (result.valid && result.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", quiet);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Writes one register; the enable stays high through the caller's next write
	// and drops at the end of set_config, so it never toggles twice in a time step.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] al, input logic [15:0] ah,
		input logic [15:0] pl, input logic [15:0] ph, input logic [31:0] mean,
		input logic [30:0] width, input logic [31:0] norm);
		write_reg(REG_ALPHA_LOW, {16'd0, al});
		write_reg(REG_ALPHA_HIGH, {16'd0, ah});
		write_reg(REG_POWER_LOW, {16'd0, pl});
		write_reg(REG_POWER_HIGH, {16'd0, ph});
		write_reg(REG_PEAK_MEAN, mean);
		write_reg(REG_CORE_WIDTH, {1'b0, width});
		write_reg(REG_NORM_SCALE, norm);
		@(negedge clk);
		cfg_we    = 1'b0;
		cur_mean  = mean;
		cur_width = width;
	endtask

	// Sends one sample beat, with random gaps ahead of it in sender idling
	// patterns. valid stays high into the next beat when no gap follows.
	task automatic send_sample(input logic [31:0] x);
		int gap_pct;
		gap_pct = (idle_mode == MODE_SENDER) ? 85 : (idle_mode == MODE_BOTH) ? 17 : 0;
		while ($urandom_range(99) < gap_pct) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid   <= 1'b1;
		sample.x_value <= x;
		do @(posedge clk); while (!sample.ready);
		@(negedge clk);
	endtask

	task automatic end_burst;
		sample.valid <= 1'b0;
	endtask

	// Waits until every expected result is back and the pipe has emptied.
	task automatic drain;
		end_burst();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// A sample placed a random number of sigmas from the center, so that all
	// three regions and their edges are hit; otherwise a fully random position.
	function automatic logic [31:0] pick_sample;
		longint off;
		if ($urandom_range(99) < 65) begin
			off = longint'(cur_width) * $urandom_range(0, 12000) / 1000;
			if ($urandom_range(1)) off = -off;
			return 32'(longint'(cur_mean) + off);
		end
		return $urandom;
	endfunction

	initial begin
		logic [31:0] edge_pts[$];
		idle_mode      = MODE_NONE;
		hold_left      = 0;
		cfg_we         = 1'b0;
		cfg_index      = REG_ALPHA_LOW;
		cfg_wdata      = '0;
		sample.valid   = 1'b0;
		sample.x_value = '0;
		result.ready   = 1'b0;
		cur_mean       = 32'sd26214400;
		cur_width      = 31'd655360;
		arst_n         = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings: field extremes, the center,
		// both region edges (alpha = 1 sigma) and points deep in each tail.
		edge_pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
			32'd26214400, 32'd26214400 - 32'd655360, 32'd26214400 - 32'd655361,
			32'd26214400 + 32'd655360, 32'd26214400 + 32'd655361,
			32'd26214400 - 32'd6553600, 32'd26214400 + 32'd6553600,
			32'd26214400 + 32'd1, 32'd26214400 - 32'd1};
		foreach (edge_pts[i]) send_sample(edge_pts[i]);
		drain();

		// Zero alpha, power and width act as their smallest value; a full-scale
		// normalization drives the output to its maximum near the center.
		set_config(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 31'd0, 32'hFFFF_FFFF);
		edge_pts = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
		foreach (edge_pts[i]) send_sample(edge_pts[i]);
		drain();

		// Widest tails and steepest powers, with a zero normalization.
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000,
			31'h7FFF_FFFF, 32'd0);
		edge_pts = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
		foreach (edge_pts[i]) send_sample(edge_pts[i]);
		drain();

		// Random phases: each picks an idling pattern and new settings, one at the
		// extremes, the rest random with a width fully random or at most 2^20.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: idle_mode = MODE_NONE;
				1: idle_mode = MODE_SENDER;
				2: idle_mode = MODE_RECV;
				default: idle_mode = MODE_BOTH;
			endcase
			if (phase == 3)
				set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 32'h7FFF_FFFF,
					31'd1, 32'hFFFF_FFFF);
			else
				set_config(16'($urandom_range(1, 16'hFFFF)),
					16'($urandom_range(1, 16'h7FFF)),
					16'($urandom_range(1, 16'hFFFF)),
					16'($urandom_range(1, 16'h0FFF)),
					$urandom, ($urandom_range(1) ? 31'($urandom)
					: 31'($urandom_range(1, 1 << 20))),
					$urandom);
			// Long receiver hold-off while the sender keeps offering beats, so
			// the output buffer fills and the chain halts with beats still in it.
			if (phase == 4) hold_left = 600;
			for (int i = 0; i < 140; i++) begin
				send_sample(pick_sample());
				// Once mid-phase the sender pauses until everything is back.
				if (phase == 5 && i == 70) drain();
			end
			drain();
		end

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: double_sided_crystal_ball_eval_top.f
rtl/dscb_pkg.sv
rtl/dscb_if.sv
rtl/dscb_div_cell.sv
rtl/dscb_log_cell.sv
rtl/dscb_exp_cell.sv
rtl/double_sided_crystal_ball_eval_top.sv
test/dscb_checker.sv
test/tb.sv
